[src/tlpf_pkg.sv]
`default_nettype none

package tlpf_pkg;

   // Fixed field widths of the command and result items
   localparam int CMD_W    = 1;
   localparam int PRIO_W   = 2;
   localparam int DATA_W   = 32;
   localparam int CAP_W    = 5;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 2;
   localparam int LEVELS   = 3;

   // Commands
   localparam logic [CMD_W-1:0] CMD_PUT = 1'b0;
   localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

   // Priority levels; code 3 names no queue
   localparam logic [PRIO_W-1:0] LVL_HIGH   = 2'd0;
   localparam logic [PRIO_W-1:0] LVL_MEDIUM = 2'd1;
   localparam logic [PRIO_W-1:0] LVL_LOW    = 2'd2;
   localparam logic [PRIO_W-1:0] LVL_NONE   = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_CAP_HIGH   = 2'd0;
   localparam logic [IDX_W-1:0] REG_CAP_MEDIUM = 2'd1;
   localparam logic [IDX_W-1:0] REG_CAP_LOW    = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Storage operation from the control block to the queue store
   typedef struct packed {
      logic              put_ok;
      logic              get_ok;
      logic [PRIO_W-1:0] lvl;
   } op_type;

   // Result fields computed in the accept cycle
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PRIO_W-1:0]   served;
      logic [COUNT_W-1:0]  used_high;
      logic [COUNT_W-1:0]  used_medium;
      logic [COUNT_W-1:0]  used_low;
      logic                all_empty;
   } rsp_info_type;

endpackage

`default_nettype wire

[src/tlpf_store.sv]
`default_nettype none

module tlpf_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire tlpf_pkg::op_type             op,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]             wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [WIDTH-1:0]             rd_data
);
   import tlpf_pkg::*;

   logic [WIDTH-1:0]  store_high_ff   [DEPTH];
   logic [WIDTH-1:0]  store_medium_ff [DEPTH];
   logic [WIDTH-1:0]  store_low_ff    [DEPTH];
   logic [WIDTH-1:0]  rd_high_ff;
   logic [WIDTH-1:0]  rd_medium_ff;
   logic [WIDTH-1:0]  rd_low_ff;
   logic [PRIO_W-1:0] rd_lvl_ff;

   // one write port per queue
   always_ff @(posedge clock) begin
      if (op.put_ok) begin
         case (op.lvl)
            LVL_HIGH:   store_high_ff[wr_addr]   <= wr_data;
            LVL_MEDIUM: store_medium_ff[wr_addr] <= wr_data;
            LVL_LOW:    store_low_ff[wr_addr]    <= wr_data;
            default: ;
         endcase
      end
   end

   // registered read, one port per queue
   always_ff @(posedge clock) begin
      if (op.get_ok) begin
         rd_lvl_ff <= op.lvl;
         case (op.lvl)
            LVL_HIGH:   rd_high_ff   <= store_high_ff[rd_addr];
            LVL_MEDIUM: rd_medium_ff <= store_medium_ff[rd_addr];
            LVL_LOW:    rd_low_ff    <= store_low_ff[rd_addr];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (rd_lvl_ff)
         LVL_HIGH:   rd_data = rd_high_ff;
         LVL_MEDIUM: rd_data = rd_medium_ff;
         default:    rd_data = rd_low_ff;
      endcase
   end

endmodule

`default_nettype wire

[src/tlpf_ctrl.sv]
`default_nettype none

module tlpf_ctrl #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [tlpf_pkg::CMD_W-1:0]          cmd,
   input  wire logic [tlpf_pkg::PRIO_W-1:0]         prio,
   input  wire logic                                csr_we,
   input  wire logic [tlpf_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [tlpf_pkg::CAP_W-1:0]          csr_wdata,
   output tlpf_pkg::op_type                         op,
   output logic      [$clog2(DEPTH)-1:0]            wr_addr,
   output logic      [$clog2(DEPTH)-1:0]            rd_addr,
   output tlpf_pkg::rsp_info_type                   info
);
   import tlpf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;

   logic [CAP_W-1:0]   cap_ff   [LEVELS];
   logic [PTR_W-1:0]   wptr_ff  [LEVELS];
   logic [PTR_W-1:0]   wptr_in  [LEVELS];
   logic [PTR_W-1:0]   rptr_ff  [LEVELS];
   logic [PTR_W-1:0]   rptr_in  [LEVELS];
   logic [COUNT_W-1:0] count_ff [LEVELS];
   logic [COUNT_W-1:0] count_in [LEVELS];
   logic [CAP_W-1:0]   eff_cap  [LEVELS];
   logic [PRIO_W-1:0]  get_lvl;
   logic               any_held;
   logic               csr_hit;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(ptr) + CMP_W'(1);
      return (nxt >= CMP_W'(cap)) ? '0 : PTR_W'(nxt);
   endfunction

   // zero acts as one, anything above the storage depth is clamped
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         if (cap_ff[i] == '0) begin
            eff_cap[i] = CAP_W'(1);
         end else if (32'(cap_ff[i]) > DEPTH) begin
            eff_cap[i] = CAP_W'(DEPTH);
         end else begin
            eff_cap[i] = cap_ff[i];
         end
      end
   end

   // fixed priority pick for a get
   always_comb begin
      any_held = 1'b1;
      if (count_ff[LVL_HIGH] != '0) begin
         get_lvl = LVL_HIGH;
      end else if (count_ff[LVL_MEDIUM] != '0) begin
         get_lvl = LVL_MEDIUM;
      end else if (count_ff[LVL_LOW] != '0) begin
         get_lvl = LVL_LOW;
      end else begin
         get_lvl  = LVL_NONE;
         any_held = 1'b0;
      end
   end

   always_comb begin
      op          = '0;
      info        = '0;
      wr_addr     = wptr_ff[LVL_HIGH];
      rd_addr     = rptr_ff[LVL_HIGH];
      wptr_in     = wptr_ff;
      rptr_in     = rptr_ff;
      count_in    = count_ff;
      info.status = ST_DONE;
      info.served = LVL_HIGH;
      if (accept) begin
         if (cmd == CMD_PUT) begin
            if (prio == LVL_NONE) begin
               info.status = ST_FULL;
            end else begin
               info.served = prio;
               if (count_ff[prio] >= eff_cap[prio]) begin
                  info.status = ST_FULL;
               end else begin
                  op.put_ok       = 1'b1;
                  op.lvl          = prio;
                  wr_addr         = wptr_ff[prio];
                  wptr_in[prio]   = advance(wptr_ff[prio], eff_cap[prio]);
                  count_in[prio]  = count_ff[prio] + COUNT_W'(1);
               end
            end
         end else begin
            if (!any_held) begin
               info.status = ST_EMPTY;
            end else begin
               op.get_ok         = 1'b1;
               op.lvl            = get_lvl;
               info.served       = get_lvl;
               rd_addr           = rptr_ff[get_lvl];
               rptr_in[get_lvl]  = advance(rptr_ff[get_lvl], eff_cap[get_lvl]);
               count_in[get_lvl] = count_ff[get_lvl] - COUNT_W'(1);
            end
         end
      end
      info.used_high   = count_in[LVL_HIGH];
      info.used_medium = count_in[LVL_MEDIUM];
      info.used_low    = count_in[LVL_LOW];
      info.all_empty   = (count_in[LVL_HIGH] == '0) && (count_in[LVL_MEDIUM] == '0) &&
                         (count_in[LVL_LOW] == '0);
   end

   assign csr_hit = csr_we && (csr_index inside {REG_CAP_HIGH, REG_CAP_MEDIUM, REG_CAP_LOW});

   // a capacity write flushes its queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            cap_ff[i]   <= CAP_RESET;
            wptr_ff[i]  <= '0;
            rptr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
         if (csr_hit) begin
            cap_ff[csr_index]   <= csr_wdata;
            wptr_ff[csr_index]  <= '0;
            rptr_ff[csr_index]  <= '0;
            count_ff[csr_index] <= '0;
         end
      end
   end

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      (count_ff[LVL_HIGH] <= eff_cap[LVL_HIGH]) &&
      (count_ff[LVL_MEDIUM] <= eff_cap[LVL_MEDIUM]) &&
      (count_ff[LVL_LOW] <= eff_cap[LVL_LOW]))
      else $error("fill count above capacity");

   a_get_order: assert property (@(posedge clock) disable iff (reset)
      op.get_ok && op.lvl != LVL_HIGH |-> count_ff[LVL_HIGH] == '0)
      else $error("lower queue served while high queue holds items");

   a_put_count: assert property (@(posedge clock) disable iff (reset)
      op.put_ok && op.lvl == LVL_HIGH && !csr_we |=>
         count_ff[LVL_HIGH] == $past(count_ff[LVL_HIGH]) + COUNT_W'(1))
      else $error("high fill count did not follow put");

endmodule

`default_nettype wire

[src/three_level_priority_fifo.sv]
// Channel   Ports                                   Handshake
// command   req_cmd, req_prio, req_payload          start high and busy low at clock edge
// result    rsp_status, rsp_data_out, rsp_served_prio,
//           rsp_used_high/medium/low, rsp_all_empty rsp_strobe high for one cycle
// config    csr_index, csr_wdata                    csr_we high at clock edge
//
// One item per cycle; busy is never raised. The result of an item accepted at
// one edge is on the rsp_ ports for the following cycle, set by the
// registered read of the queue store. Synchronous active-high reset empties all
// queues and sets every capacity to 16. The receiver cannot stall: each result
// is taken in the one cycle it is shown.
`default_nettype none

module three_level_priority_fifo #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [tlpf_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [tlpf_pkg::PRIO_W-1:0]         req_prio,
   input  wire logic [tlpf_pkg::DATA_W-1:0]         req_payload,
   // result
   output logic                                     rsp_strobe,
   output logic      [tlpf_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [tlpf_pkg::DATA_W-1:0]         rsp_data_out,
   output logic      [tlpf_pkg::PRIO_W-1:0]         rsp_served_prio,
   output logic      [tlpf_pkg::COUNT_W-1:0]        rsp_used_high,
   output logic      [tlpf_pkg::COUNT_W-1:0]        rsp_used_medium,
   output logic      [tlpf_pkg::COUNT_W-1:0]        rsp_used_low,
   output logic                                     rsp_all_empty,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [tlpf_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [tlpf_pkg::CAP_W-1:0]          csr_wdata
);
   import tlpf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                 accept;
   op_type               op;
   rsp_info_type         info;
   logic [PTR_W-1:0]     wr_addr;
   logic [PTR_W-1:0]     rd_addr;
   logic [63:0]          payload_wide;
   logic [PAYLOAD_BITS-1:0] wr_data;
   logic [PAYLOAD_BITS-1:0] rd_data;
   logic [63:0]          rd_wide;

   logic                 rsp_strobe_ff;
   rsp_info_type         rsp_info_ff;
   logic                 get_ok_ff;

   // all work fits in the accept cycle, so commands are always taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // upper payload bits beyond the stored width are dropped
   assign payload_wide = 64'(req_payload);
   assign wr_data      = payload_wide[PAYLOAD_BITS-1:0];

   tlpf_ctrl #(
      .DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .prio      (req_prio),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op        (op),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   tlpf_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (PAYLOAD_BITS)
   ) u_store (
      .clock   (clock),
      .op      (op),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register; the read data register sits in the store
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_info_ff <= info;
         get_ok_ff   <= op.get_ok;
      end
   end

   assign rd_wide = 64'(rd_data);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_info_ff.status;
   assign rsp_data_out    = get_ok_ff ? rd_wide[DATA_W-1:0] : '0;
   assign rsp_served_prio = rsp_info_ff.served;
   assign rsp_used_high   = rsp_info_ff.used_high;
   assign rsp_used_medium = rsp_info_ff.used_medium;
   assign rsp_used_low    = rsp_info_ff.used_low;
   assign rsp_all_empty   = rsp_info_ff.all_empty;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start))
      else $error("result without a command");

   a_data_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_DONE |-> rsp_data_out == '0)
      else $error("data on a failed command");

   a_empty_get: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY |-> rsp_all_empty && rsp_served_prio == LVL_HIGH)
      else $error("empty status while queues hold items");

endmodule

`default_nettype wire
